// ----- hw/rtl/cdm_pkg.sv -----
// ----------------------------------------------------------------------------
// Card detect mount package
// Shared types and constants for the card detect and mount state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package cdm_pkg;

  // Register map and widths.
  localparam int unsigned CdmAddrWidth = 3;
  localparam int unsigned CdmDataWidth = 32;
  localparam int unsigned CdmTickWidth = 16;

  // Register reset values.
  localparam logic [CdmTickWidth-1:0] CdmDebounceTicksRst = 16'd500;
  localparam logic                    CdmSystemBootedRst  = 1'b1;

  // Register indexes, taken from the word address.
  typedef enum logic {
    CDM_REG_DEBOUNCE_TICKS = 1'b0,
    CDM_REG_SYSTEM_BOOTED  = 1'b1
  } cdm_reg_e;

  // Card states, encoded as they appear on the result beat.
  typedef enum logic [2:0] {
    CDM_ST_START     = 3'd0,
    CDM_ST_MOUNTED   = 3'd1,
    CDM_ST_FAILED    = 3'd2,
    CDM_ST_UNMOUNTED = 3'd3,
    CDM_ST_DEBOUNCE  = 3'd4
  } cdm_state_e;

  // Sample kinds on the cmd field.
  typedef enum logic {
    CDM_CMD_IRQ  = 1'b0,
    CDM_CMD_TICK = 1'b1
  } cdm_cmd_e;

  // One presence sample.
  typedef struct packed {
    logic cmd;
    logic card_present;
    logic usb_storage_active;
    logic usb_selects_card;
    logic mount_ok;
  } cdm_in_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] state_code;
    logic       card_mounted;
    logic       media_fault;
    logic       mount_attempt;
    logic       unmount_pulse;
    logic       state_changed;
    logic       profile_reload;
  } cdm_out_t;

endpackage : cdm_pkg

`default_nettype wire

// ----- hw/rtl/card_detect_mount_fsm.sv -----
// ----------------------------------------------------------------------------
// Card detect mount state machine
// Follows a removable card through start, mounted, mount failed, unmounted
// and debounce, with a millisecond debounce timer and mount outcome input.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  ------------------------
//   in        sink       in_valid_i / in_stall_o   in_data_i  (cdm_in_t)
//   out       source     out_valid_o / out_stall_i out_data_o (cdm_out_t)
//   config    APB slave  psel / penable / pready   pwdata / prdata
//
// For each sample, the next state and the result beat are formed in one
// pass of logic from the state registers and land in the output register
// on the accepting edge, so a beat can be taken every cycle.
// The input stalls only while the output register holds a beat that the
// downstream side is stalling.
// Reset puts the machine in start with the timer disarmed and the registers
// at their reset values; no clearing pass is needed.
//
`default_nettype none

module card_detect_mount_fsm (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Sample channel
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire cdm_pkg::cdm_in_t                     in_data_i,
  // Result channel
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      cdm_pkg::cdm_out_t                    out_data_o,
  // Configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [cdm_pkg::CdmAddrWidth-1:0]     paddr,
  input  wire logic [cdm_pkg::CdmDataWidth-1:0]     pwdata,
  output      logic [cdm_pkg::CdmDataWidth-1:0]     prdata,
  output      logic                                 pready
);

  import cdm_pkg::*;

  // Configuration registers.
  logic [CdmTickWidth-1:0] debounce_ticks_q;
  logic                    system_booted_q;

  // Machine state.
  cdm_state_e              state_q, state_d;
  logic [CdmTickWidth-1:0] elapsed_q, elapsed_d;
  logic                    armed_q, armed_d;
  logic                    fault_q, fault_d;

  // Output register.
  logic                    out_valid_q;
  cdm_out_t                out_q, out_d;

  logic                    in_accept;
  logic                    out_accept;
  logic                    cfg_write;
  cdm_reg_e                cfg_reg;

  // Temporaries of the single pass.
  logic                    present;
  logic                    is_tick;
  logic [CdmTickWidth-1:0] elapsed_adv;
  logic                    attempt;
  logic                    unmount;
  logic                    reload;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;

  // APB register access; the word address picks the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = cdm_reg_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    case (cfg_reg)
      CDM_REG_DEBOUNCE_TICKS: prdata[CdmTickWidth-1:0] = debounce_ticks_q;
      CDM_REG_SYSTEM_BOOTED:  prdata[0] = system_booted_q;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= CdmDebounceTicksRst;
      system_booted_q  <= CdmSystemBootedRst;
    end else if (cfg_write) begin
      case (cfg_reg)
        CDM_REG_DEBOUNCE_TICKS: debounce_ticks_q <= pwdata[CdmTickWidth-1:0];
        CDM_REG_SYSTEM_BOOTED:  system_booted_q  <= pwdata[0];
        default:                ;
      endcase
    end
  end

  // Next state and result beat: timer advance, presence event, then timeout.
  always_comb begin
    is_tick = (in_data_i.cmd == CDM_CMD_TICK);
    present = in_data_i.card_present &&
              !(in_data_i.usb_storage_active && in_data_i.usb_selects_card);

    // An armed timer counts ticks and saturates at full scale.
    elapsed_adv = elapsed_q;
    if (is_tick && armed_q && (elapsed_q != '1)) begin
      elapsed_adv = elapsed_q + CdmTickWidth'(1);
    end

    state_d   = state_q;
    elapsed_d = elapsed_adv;
    armed_d   = armed_q;
    fault_d   = fault_q;
    attempt   = 1'b0;
    unmount   = 1'b0;
    reload    = 1'b0;

    // Presence event; every transition here enters a new state.
    case (state_q)
      CDM_ST_START: begin
        if (present) begin
          attempt = 1'b1;
          if (in_data_i.mount_ok) begin
            state_d = CDM_ST_MOUNTED;
            fault_d = 1'b0;
            reload  = system_booted_q;
          end else begin
            state_d = CDM_ST_FAILED;
            fault_d = 1'b1;
          end
        end else begin
          state_d = CDM_ST_UNMOUNTED;
          fault_d = 1'b1;
        end
      end
      CDM_ST_MOUNTED: begin
        if (!present) begin
          unmount = 1'b1;
          state_d = CDM_ST_UNMOUNTED;
          fault_d = 1'b1;
        end
      end
      CDM_ST_FAILED: begin
        if (!present) begin
          state_d = CDM_ST_UNMOUNTED;
          fault_d = 1'b1;
        end
      end
      CDM_ST_UNMOUNTED: begin
        if (present) begin
          state_d   = CDM_ST_DEBOUNCE;
          fault_d   = 1'b1;
          armed_d   = 1'b1;
          elapsed_d = '0;
        end
      end
      CDM_ST_DEBOUNCE: begin
        if (!present) begin
          state_d = CDM_ST_UNMOUNTED;
          fault_d = 1'b1;
          armed_d = 1'b0;
        end
      end
      default: ;
    endcase

    // Timeout: the debounce window has run out, so try the mount.
    if (is_tick && armed_d && (elapsed_d >= debounce_ticks_q)) begin
      armed_d = 1'b0;
      if (state_d == CDM_ST_DEBOUNCE) begin
        attempt = 1'b1;
        if (in_data_i.mount_ok) begin
          state_d = CDM_ST_MOUNTED;
          fault_d = 1'b0;
          reload  = reload || system_booted_q;
        end else begin
          state_d = CDM_ST_FAILED;
          fault_d = 1'b1;
        end
      end
    end

    out_d.state_code     = state_d;
    out_d.card_mounted   = (state_d == CDM_ST_MOUNTED);
    out_d.media_fault    = fault_d;
    out_d.mount_attempt  = attempt;
    out_d.unmount_pulse  = unmount;
    out_d.state_changed  = (state_d != state_q);
    out_d.profile_reload = reload;
  end

  // State registers advance on every accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CDM_ST_START;
      elapsed_q <= '0;
      armed_q   <= 1'b0;
      fault_q   <= 1'b0;
    end else if (in_accept) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      armed_q   <= armed_d;
      fault_q   <= fault_d;
    end
  end

  // Output register: filled by an accepted sample, emptied by a taken beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The debounce timer is only ever armed while debouncing.
  a_armed_in_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (state_q == CDM_ST_DEBOUNCE))
    else $error("debounce timer armed outside debounce state");

  // An accepted sample always leaves a beat in the output register.
  a_accept_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted sample produced no result beat");

  // The reported state follows the state register after each sample.
  a_state_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (out_q.state_code == state_q))
    else $error("result state differs from state register");

  // A profile reload only comes with a freshly mounted card.
  a_reload_mounted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.profile_reload) |->
      (out_q.card_mounted && out_q.state_changed))
    else $error("profile reload without entering mounted");

  // Once start is left, the fault flag is the inverse of mounted.
  a_fault_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != CDM_ST_START) |-> (fault_q == (state_q != CDM_ST_MOUNTED)))
    else $error("media fault flag out of step with state");

endmodule : card_detect_mount_fsm

`default_nettype wire
